@@ rtl/core/kcs_pkg.sv @@
// kcs_pkg: shared widths, fixed-point constants and register indexes
// for the coefficient search block. No dependencies.
package kcs_pkg;

  localparam int CAND_W  = 24;
  localparam int DIM_W   = 5;
  localparam int RECIP_W = 39;
  localparam int H_W     = 56;
  localparam int SUM_W   = 54;
  localparam int MAG_W   = 34;
  localparam int FMAG_W  = 54;
  localparam int CFG_W   = 56;
  localparam int IDX_W   = 2;
  localparam int HACC_W  = 112;

  localparam logic [IDX_W-1:0] REG_MODULUS    = 2'd0;
  localparam logic [IDX_W-1:0] REG_DIMENSIONS = 2'd1;
  localparam logic [IDX_W-1:0] REG_RECIPROCAL = 2'd2;
  localparam logic [IDX_W-1:0] REG_SCALE      = 2'd3;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 39'd366503875925;
  localparam logic [FMAG_W-1:0]  ONE_Q30     = 54'd1 << 30;
  localparam logic [SUM_W-1:0]   SUM_MAX     = '1;
  localparam logic [H_W-1:0]     H_MAX       = '1;

endpackage

@@ rtl/core/kcs_req_if.sv @@
// kcs_req_if: request channel carrying one candidate multiplier.
// Depends on kcs_pkg.
interface kcs_req_if;
  logic                        valid;
  logic                        ready;
  logic [kcs_pkg::CAND_W-1:0]  candidate;
  logic                        restart_best;

  modport source (output valid, candidate, restart_best, input ready);
  modport sink   (input valid, candidate, restart_best, output ready);
endinterface

@@ rtl/core/kcs_rsp_if.sv @@
// kcs_rsp_if: result channel carrying H and the best candidate so far.
// Depends on kcs_pkg.
interface kcs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [kcs_pkg::H_W-1:0]    h_value;
  logic [kcs_pkg::CAND_W-1:0] best_candidate;
  logic [kcs_pkg::H_W-1:0]    best_value;

  modport source (output valid, h_value, best_candidate, best_value, input ready);
  modport sink   (input valid, h_value, best_candidate, best_value, output ready);
endinterface

@@ rtl/core/korobov_coefficient_search.sv @@
// korobov_coefficient_search: Korobov lattice coefficient evaluator.
// Depends on kcs_pkg, kcs_req_if, kcs_rsp_if and kcs_mul32.
//
// Usage: write modulus, dimensions, reciprocal and scale through the
// cfg_we/cfg_index/cfg_data port while idle. Each request on req carries a
// candidate z and a restart flag; one result follows on rsp with H for z,
// the first candidate with the smallest H so far and that H.
// Steps: z mod p is formed bit-serially, each power z^j by shift-and-add
// modulo p, then every lattice point i = 1..(p-1)/2 takes d factors through
// the shared 32x32 multiplier and the power/residue memory, then the square
// and the sum; H is formed last from the sum and the scale.
// One request is worked on at a time; req.ready is high only when idle.
// A finished result sits in an output register, so the next request is
// taken while it waits; if rsp stalls, the following result holds at its
// final step until the register frees.
// Reset clears the control, the sum and the best tracking (best H all ones,
// best candidate 0) and loads the register reset values. The memory of
// powers and residues is rewritten for every request before it is read.
module korobov_coefficient_search #(
  parameter int MAX_DIM  = 20,
  parameter int MOD_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [kcs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [kcs_pkg::CFG_W-1:0]  cfg_data,
  kcs_req_if.sink                    req,
  kcs_rsp_if.source                  rsp
);

  localparam int PW  = (MOD_BITS < kcs_pkg::CAND_W) ? MOD_BITS : kcs_pkg::CAND_W;
  localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DCW = $clog2(MAX_DIM + 1);
  localparam int KW  = $clog2(PW);
  localparam int ZCW = $clog2(kcs_pkg::CAND_W);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ZMOD     = 5'd1;
  localparam logic [4:0] S_PWR_WR   = 5'd2;
  localparam logic [4:0] S_PWR_MUL  = 5'd3;
  localparam logic [4:0] S_PT_INIT  = 5'd4;
  localparam logic [4:0] S_RD       = 5'd5;
  localparam logic [4:0] S_UPD      = 5'd6;
  localparam logic [4:0] S_V0       = 5'd7;
  localparam logic [4:0] S_V1       = 5'd8;
  localparam logic [4:0] S_V2       = 5'd9;
  localparam logic [4:0] S_V3       = 5'd10;
  localparam logic [4:0] S_F0       = 5'd11;
  localparam logic [4:0] S_F1       = 5'd12;
  localparam logic [4:0] S_F2       = 5'd13;
  localparam logic [4:0] S_F3       = 5'd14;
  localparam logic [4:0] S_SQ0      = 5'd15;
  localparam logic [4:0] S_SQ1      = 5'd16;
  localparam logic [4:0] S_SQ2      = 5'd17;
  localparam logic [4:0] S_SQ3      = 5'd18;
  localparam logic [4:0] S_HB       = 5'd19;
  localparam logic [4:0] S_H0       = 5'd20;
  localparam logic [4:0] S_H1       = 5'd21;
  localparam logic [4:0] S_H2       = 5'd22;
  localparam logic [4:0] S_H3       = 5'd23;
  localparam logic [4:0] S_H4       = 5'd24;
  localparam logic [4:0] S_H5       = 5'd25;
  localparam logic [4:0] S_FIN      = 5'd26;

  // configuration
  logic [PW-1:0]                     modulus;
  logic [kcs_pkg::DIM_W-1:0]         dimensions;
  logic [kcs_pkg::RECIP_W-1:0]       reciprocal;
  logic [kcs_pkg::H_W-1:0]           scale;

  // control and datapath
  logic [4:0]                        state;
  logic [kcs_pkg::CAND_W-1:0]        cand;
  logic [kcs_pkg::CAND_W-1:0]        zsh;
  logic [ZCW-1:0]                    zc;
  logic [PW-1:0]                     zr;
  logic [PW-1:0]                     zs;
  logic [PW-1:0]                     zm;
  logic [PW-1:0]                     macc;
  logic [KW-1:0]                     kc;
  logic [DCW-1:0]                    jc;
  logic [PW-2:0]                     ic;
  logic [PW-1:0]                     rr;
  logic [kcs_pkg::FMAG_W-1:0]        v;
  logic [kcs_pkg::FMAG_W-1:0]        fmag;
  logic [kcs_pkg::MAG_W-1:0]         mag;
  logic [kcs_pkg::MAG_W-1:0]         sq;
  logic [63:0]                       tmp;
  logic [kcs_pkg::SUM_W-1:0]         square_sum;
  logic [kcs_pkg::H_W-1:0]           hb;
  logic [kcs_pkg::HACC_W-1:0]        hacc;
  logic [kcs_pkg::H_W-1:0]           h;
  logic [kcs_pkg::CAND_W-1:0]        best_index;
  logic [kcs_pkg::H_W-1:0]           best_h;
  logic                              out_valid;
  logic [kcs_pkg::H_W-1:0]           out_h;
  logic [kcs_pkg::CAND_W-1:0]        out_best_idx;
  logic [kcs_pkg::H_W-1:0]           out_best_h;

  // power / residue memory: {power_step, residue}
  logic [2*PW-1:0]                   mem [MAX_DIM];
  logic [2*PW-1:0]                   mem_q;
  logic                              mem_we;
  logic [2*PW-1:0]                   mem_wd;

  logic [31:0]                       mul_a;
  logic [31:0]                       mul_b;
  logic [63:0]                       prod;

  logic                              req_acc;
  logic [DCW-1:0]                    d_eff;
  logic [PW-2:0]                     half;
  logic [PW:0]                       ztrial;
  logic [PW-1:0]                     zrem_next;
  logic [PW:0]                       mdbl;
  logic [PW-1:0]                     mdbl_red;
  logic [PW:0]                       madd;
  logic [PW-1:0]                     macc_next;
  logic [PW:0]                       rsum;
  logic [PW-1:0]                     r_next;
  logic [63:0]                       vsum;
  logic [63:0]                       vfull;
  logic [63:0]                       fsum;
  logic [63:0]                       qsum;
  logic [kcs_pkg::SUM_W:0]           ssum;
  logic [kcs_pkg::HACC_W-1:0]        hround;
  logic                              h_better;

  assign req_acc   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign d_eff     = (32'(dimensions) > 32'(MAX_DIM)) ? DCW'(MAX_DIM) : DCW'(dimensions);
  assign half      = (PW-1)'((modulus - PW'(1)) >> 1);

  assign ztrial    = {zr, zsh[kcs_pkg::CAND_W-1]};
  assign zrem_next = (ztrial >= {1'b0, modulus}) ? PW'(ztrial - {1'b0, modulus})
                                                 : ztrial[PW-1:0];
  assign mdbl      = {macc, 1'b0};
  assign mdbl_red  = (mdbl >= {1'b0, modulus}) ? PW'(mdbl - {1'b0, modulus})
                                               : mdbl[PW-1:0];
  assign madd      = {1'b0, mdbl_red} + (zm[PW-1] ? {1'b0, zs} : '0);
  assign macc_next = (madd >= {1'b0, modulus}) ? PW'(madd - {1'b0, modulus})
                                               : madd[PW-1:0];
  assign rsum      = {1'b0, mem_q[PW-1:0]} + {1'b0, mem_q[2*PW-1:PW]};
  assign r_next    = (rsum >= {1'b0, modulus}) ? PW'(rsum - {1'b0, modulus})
                                               : rsum[PW-1:0];
  assign vsum      = tmp + {prod[31:0], 32'd0};
  assign vfull     = {vsum[62:0], 1'b0} + 64'd512;
  assign fsum      = tmp + {prod[31:0], 32'd0} + 64'd536870912;
  assign qsum      = tmp + {prod[30:0], 33'd0} + 64'd536870912;
  assign ssum      = {1'b0, square_sum} + (kcs_pkg::SUM_W + 1)'(sq);
  assign hround    = hacc + kcs_pkg::HACC_W'(64'd536870912);
  assign h_better  = (h < best_h);

  always_comb begin
    unique case (state)
      S_V0:    begin mul_a = 32'(rr);        mul_b = reciprocal[31:0]; end
      S_V1:    begin mul_a = 32'(rr);        mul_b = 32'(reciprocal[38:32]); end
      S_F0:    begin mul_a = mag[31:0];      mul_b = fmag[31:0]; end
      S_F1:    begin mul_a = mag[31:0];      mul_b = 32'(fmag[53:32]); end
      S_F2:    begin mul_a = 32'(mag[33:32]); mul_b = fmag[31:0]; end
      S_SQ0:   begin mul_a = mag[31:0];      mul_b = mag[31:0]; end
      S_SQ1:   begin mul_a = mag[31:0];      mul_b = 32'(mag[33:32]); end
      S_H0:    begin mul_a = scale[31:0];    mul_b = hb[31:0]; end
      S_H1:    begin mul_a = scale[31:0];    mul_b = 32'(hb[55:32]); end
      S_H2:    begin mul_a = 32'(scale[55:32]); mul_b = hb[31:0]; end
      S_H3:    begin mul_a = 32'(scale[55:32]); mul_b = 32'(hb[55:32]); end
      default: begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  kcs_mul32 u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wd = {zs, PW'(0)};
    if (state == S_PWR_WR && jc != d_eff) begin
      mem_we = 1'b1;
    end else if (state == S_UPD) begin
      mem_we = 1'b1;
      mem_wd = {mem_q[2*PW-1:PW], r_next};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[jc[AW-1:0]] <= mem_wd;
    end
    if (state == S_RD) begin
      mem_q <= mem[jc[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= PW'(3);
      dimensions <= kcs_pkg::DIM_W'(1);
      reciprocal <= kcs_pkg::RECIP_RESET;
      scale      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcs_pkg::REG_MODULUS:    modulus    <= cfg_data[PW-1:0];
        kcs_pkg::REG_DIMENSIONS: dimensions <= cfg_data[kcs_pkg::DIM_W-1:0];
        kcs_pkg::REG_RECIPROCAL: reciprocal <= cfg_data[kcs_pkg::RECIP_W-1:0];
        kcs_pkg::REG_SCALE:      scale      <= cfg_data[kcs_pkg::H_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      square_sum <= '0;
      best_index <= '0;
      best_h     <= kcs_pkg::H_MAX;
      out_valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            cand <= req.candidate;
            zsh  <= req.candidate;
            zr   <= '0;
            zc   <= '0;
            if (req.restart_best) begin
              best_h     <= kcs_pkg::H_MAX;
              best_index <= '0;
            end
            if (modulus >= PW'(3)) begin
              state <= S_ZMOD;
            end else begin
              square_sum <= '0;
              state      <= S_HB;
            end
          end
        end
        S_ZMOD: begin
          zr  <= zrem_next;
          zsh <= {zsh[kcs_pkg::CAND_W-2:0], 1'b0};
          zc  <= zc + ZCW'(1);
          if (zc == ZCW'(kcs_pkg::CAND_W - 1)) begin
            zs    <= PW'(1);
            jc    <= '0;
            state <= S_PWR_WR;
          end
        end
        S_PWR_WR: begin
          if (jc == d_eff) begin
            ic         <= (PW-1)'(1);
            square_sum <= '0;
            state      <= S_PT_INIT;
          end else begin
            macc  <= '0;
            zm    <= zr;
            kc    <= '0;
            state <= S_PWR_MUL;
          end
        end
        S_PWR_MUL: begin
          macc <= macc_next;
          zm   <= {zm[PW-2:0], 1'b0};
          kc   <= kc + KW'(1);
          if (kc == KW'(PW - 1)) begin
            zs    <= macc_next;
            jc    <= jc + DCW'(1);
            state <= S_PWR_WR;
          end
        end
        S_PT_INIT: begin
          mag <= kcs_pkg::MAG_W'(kcs_pkg::ONE_Q30);
          jc  <= '0;
          state <= (d_eff == '0) ? S_SQ0 : S_RD;
        end
        S_RD:  state <= S_UPD;
        S_UPD: begin
          rr    <= r_next;
          state <= S_V0;
        end
        S_V0: state <= S_V1;
        S_V1: begin
          tmp   <= prod;
          state <= S_V2;
        end
        S_V2: begin
          v     <= vfull[63:10];
          state <= S_V3;
        end
        S_V3: begin
          fmag  <= (v <= kcs_pkg::ONE_Q30) ? kcs_pkg::ONE_Q30 - v : v - kcs_pkg::ONE_Q30;
          state <= S_F0;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          tmp   <= prod;
          state <= S_F2;
        end
        S_F2: begin
          tmp   <= vsum;
          state <= S_F3;
        end
        S_F3: begin
          mag <= fsum[63:30];
          jc  <= jc + DCW'(1);
          state <= (jc + DCW'(1) == d_eff) ? S_SQ0 : S_RD;
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          tmp   <= prod;
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq    <= qsum[63:30];
          state <= S_SQ3;
        end
        S_SQ3: begin
          square_sum <= (ssum > {1'b0, kcs_pkg::SUM_MAX}) ? kcs_pkg::SUM_MAX
                                                          : ssum[kcs_pkg::SUM_W-1:0];
          if (ic == half) begin
            state <= S_HB;
          end else begin
            ic    <= ic + (PW-1)'(1);
            state <= S_PT_INIT;
          end
        end
        S_HB: begin
          hb    <= kcs_pkg::H_W'(kcs_pkg::ONE_Q30) + {1'b0, square_sum, 1'b0};
          state <= S_H0;
        end
        S_H0: state <= S_H1;
        S_H1: begin
          hacc  <= kcs_pkg::HACC_W'(prod);
          state <= S_H2;
        end
        S_H2: begin
          hacc  <= hacc + (kcs_pkg::HACC_W'(prod) << 32);
          state <= S_H3;
        end
        S_H3: begin
          hacc  <= hacc + (kcs_pkg::HACC_W'(prod) << 32);
          state <= S_H4;
        end
        S_H4: begin
          hacc  <= hacc + (kcs_pkg::HACC_W'(prod) << 64);
          state <= S_H5;
        end
        S_H5: begin
          h     <= (hround[111:86] != '0) ? kcs_pkg::H_MAX : hround[85:30];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_h        <= h;
            out_best_idx <= h_better ? cand : best_index;
            out_best_h   <= h_better ? h : best_h;
            if (h_better) begin
              best_h     <= h;
              best_index <= cand;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.h_value        = out_h;
  assign rsp.best_candidate = out_best_idx;
  assign rsp.best_value     = out_best_h;

  a_best_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(req_acc && req.restart_best) |-> best_h <= $past(best_h))
    else $error("best H increased without restart");

  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_V0) |-> (rr < modulus))
    else $error("residue not reduced below modulus");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (jc < d_eff))
    else $error("memory read beyond active dimensions");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside final step");

endmodule

@@ rtl/core/kcs_mul32.sv @@
// kcs_mul32: registered 32x32 unsigned multiplier shared by the factor, square and H phases.
// No dependencies.
module kcs_mul32 (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule
